>>> rtl/core/wtcs_pkg.sv
package wtcs_pkg;

  localparam int unsigned TIME_W     = 17;
  localparam int unsigned DAYS_W     = 7;
  localparam int unsigned WDAY_W     = 3;
  localparam int unsigned MAP_W      = 4;
  localparam int unsigned TIDX_W     = 3;
  localparam int unsigned CIDX_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned OUT_CH_W   = 4;
  localparam int unsigned OUT_TMR_W  = 8;

  // A bound at or above one full day marks the bound as unset.
  localparam logic [TIME_W-1:0] DAY_SECONDS = 17'd86400;

  // Map codes MAP_FIRST..MAP_LAST select timers 0..7.
  localparam logic [MAP_W-1:0] MAP_FIRST = 4'd2;
  localparam logic [MAP_W-1:0] MAP_LAST  = 4'd9;
  localparam int unsigned MAP_TIMERS = int'(MAP_LAST) - int'(MAP_FIRST) + 1;

  localparam logic [WDAY_W-1:0] WEEKDAY_LAST = 3'd6;
  localparam logic [DAYS_W-1:0] SUNDAY_BIT   = 7'h40;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_FIRST = 3'd1;

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_PROGRAM = 2'd1,
    KIND_SET_ONE = 2'd2,
    KIND_SET_ALL = 2'd3
  } kind_t;

  typedef struct packed {
    logic                tick;
    logic                prog;
    logic [TIDX_W-1:0]   timer_index;
    logic [TIME_W-1:0]   now;
    logic [WDAY_W-1:0]   weekday;
    logic [TIME_W-1:0]   start_sec;
    logic [TIME_W-1:0]   stop_sec;
    logic [DAYS_W-1:0]   days;
  } bank_cmd_t;

  function automatic logic window_on(
    input logic [TIME_W-1:0] start_sec,
    input logic [TIME_W-1:0] stop_sec,
    input logic [DAYS_W-1:0] days,
    input logic [TIME_W-1:0] now,
    input logic [DAYS_W-1:0] daybit
  );
    logic on;
    on = 1'b0;
    if ((days & daybit) != '0) begin
      if (start_sec < stop_sec) begin
        on = (now >= start_sec) && (now < stop_sec);
      end else if (stop_sec < start_sec) begin
        // wraps past midnight
        on = !((now >= stop_sec) && (now < start_sec));
      end
    end
    return on;
  endfunction

endpackage

>>> rtl/core/wtcs_timer_bank.sv
module wtcs_timer_bank #(
  parameter int unsigned TIMERS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wtcs_pkg::bank_cmd_t  cmd,
  output logic [TIMERS-1:0]    valid_eff,
  output logic [TIMERS-1:0]    active_eff
);

  logic [TIMERS-1:0][wtcs_pkg::TIME_W-1:0] start_r;
  logic [TIMERS-1:0][wtcs_pkg::TIME_W-1:0] stop_r;
  logic [TIMERS-1:0][wtcs_pkg::DAYS_W-1:0] days_r;
  logic [TIMERS-1:0]                       valid_r;
  logic [TIMERS-1:0]                       active_r;
  logic [TIMERS-1:0]                       valid_nxt;
  logic [TIMERS-1:0]                       active_nxt;
  logic [wtcs_pkg::DAYS_W-1:0]             daybit;

  // weekday 7 matches no day
  assign daybit = (cmd.weekday <= wtcs_pkg::WEEKDAY_LAST) ?
                  (wtcs_pkg::SUNDAY_BIT >> cmd.weekday) : '0;

  always_comb begin
    for (int t = 0; t < TIMERS; t++) begin
      valid_nxt[t]  = (start_r[t] < wtcs_pkg::DAY_SECONDS) &&
                      (stop_r[t] < wtcs_pkg::DAY_SECONDS);
      active_nxt[t] = valid_nxt[t] &&
                      wtcs_pkg::window_on(start_r[t], stop_r[t], days_r[t], cmd.now, daybit);
    end
  end

  // flags seen by this item: fresh on a tick, held otherwise
  assign valid_eff  = cmd.tick ? valid_nxt  : valid_r;
  assign active_eff = cmd.tick ? active_nxt : active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      active_r <= '0;
    end else if (cmd.tick) begin
      valid_r  <= valid_nxt;
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      stop_r  <= '0;
      days_r  <= '0;
    end else begin
      for (int t = 0; t < TIMERS; t++) begin
        if (cmd.prog && (cmd.timer_index == wtcs_pkg::TIDX_W'(t))) begin
          start_r[t] <= cmd.start_sec;
          stop_r[t]  <= cmd.stop_sec;
          days_r[t]  <= cmd.days;
        end
      end
    end
  end

endmodule

>>> rtl/core/wtcs_chan_mux.sv
module wtcs_chan_mux #(
  parameter int unsigned TIMERS = 8,
  parameter int unsigned CHANS  = 4
) (
  input  logic                                auto_mode,
  input  logic [CHANS-1:0][wtcs_pkg::MAP_W-1:0] map,
  input  logic [CHANS-1:0]                    buttons,
  input  logic [TIMERS-1:0]                   valid,
  input  logic [TIMERS-1:0]                   active,
  output logic [CHANS-1:0]                    levels
);

  always_comb begin
    for (int c = 0; c < CHANS; c++) begin
      levels[c] = buttons[c];
      for (int t = 0; t < TIMERS; t++) begin
        // in auto mode, a mapped, valid timer overrides the button
        if (auto_mode && valid[t] &&
            (map[c] == wtcs_pkg::MAP_FIRST + wtcs_pkg::MAP_W'(t))) begin
          levels[c] = active[t];
        end
      end
    end
  end

endmodule

>>> rtl/core/weekly_timer_channel_switch.sv
// Weekly timer channel switch. Items arrive on start and are taken at any
// rising edge where start is high and busy is low; busy is high only while
// rst_n holds the block in reset, so one item can be taken every cycle. Each
// item produces exactly one result, shown for a single cycle with out_valid
// high: the item is held in the input register, then passes through the
// timer compares and channel mux into the result register. The receiver
// cannot stall, so results must be taken on the strobe. A tick (kind 0)
// re-evaluates all timer windows; programming a timer takes effect at the
// next tick. Configuration writes transfer when cfg_valid and cfg_ready are
// high and must only be issued while no item is in flight.
module weekly_timer_channel_switch #(
  parameter int unsigned NUM_TIMERS   = 8,
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // item channel
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_kind,
  input  logic [wtcs_pkg::TIME_W-1:0]        in_time_of_day,
  input  logic [wtcs_pkg::WDAY_W-1:0]        in_weekday,
  input  logic [wtcs_pkg::TIDX_W-1:0]        in_timer_index,
  input  logic [wtcs_pkg::TIME_W-1:0]        in_start_second,
  input  logic [wtcs_pkg::TIME_W-1:0]        in_stop_second,
  input  logic [wtcs_pkg::DAYS_W-1:0]        in_day_mask,
  input  logic [wtcs_pkg::CIDX_W-1:0]        in_channel_index,
  input  logic                               in_button_value,
  // result channel
  output logic                               out_valid,
  output logic [wtcs_pkg::OUT_CH_W-1:0]      out_channel_outputs,
  output logic [wtcs_pkg::OUT_CH_W-1:0]      out_changed_channels,
  output logic [wtcs_pkg::OUT_CH_W-1:0]      out_button_states,
  output logic [wtcs_pkg::OUT_TMR_W-1:0]     out_timers_on,
  // configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wtcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wtcs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Only timers reachable by a map code and channels with a map register
  // can ever show up on the result ports.
  localparam int unsigned TIMERS = (NUM_TIMERS < wtcs_pkg::MAP_TIMERS) ?
                                   NUM_TIMERS : wtcs_pkg::MAP_TIMERS;
  localparam int unsigned CHANS  = (NUM_CHANNELS < wtcs_pkg::OUT_CH_W) ?
                                   NUM_CHANNELS : wtcs_pkg::OUT_CH_W;

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic                               in_vld_r;
  wtcs_pkg::kind_t                    kind_r;
  logic [wtcs_pkg::TIME_W-1:0]        now_r;
  logic [wtcs_pkg::WDAY_W-1:0]        weekday_r;
  logic [wtcs_pkg::TIDX_W-1:0]        timer_index_r;
  logic [wtcs_pkg::TIME_W-1:0]        start_sec_r;
  logic [wtcs_pkg::TIME_W-1:0]        stop_sec_r;
  logic [wtcs_pkg::DAYS_W-1:0]        days_r;
  logic [wtcs_pkg::CIDX_W-1:0]        chan_index_r;
  logic                               button_value_r;
  logic                               accept;

  assign busy   = !rst_n;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
  end

  // payload: capture on every transfer, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r         <= wtcs_pkg::kind_t'(in_kind);
      now_r          <= in_time_of_day;
      weekday_r      <= in_weekday;
      timer_index_r  <= in_timer_index;
      start_sec_r    <= in_start_second;
      stop_sec_r     <= in_stop_second;
      days_r         <= in_day_mask;
      chan_index_r   <= in_channel_index;
      button_value_r <= in_button_value;
    end
  end

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic                                    auto_mode_r;
  logic [CHANS-1:0][wtcs_pkg::MAP_W-1:0]   map_r;
  logic                                    cfg_write;

  assign cfg_ready = rst_n;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_mode_r <= 1'b0;
      map_r       <= '0;
    end else if (cfg_write) begin
      if (cfg_index == wtcs_pkg::CFG_AUTO_MODE) begin
        auto_mode_r <= cfg_data[0];
      end
      for (int c = 0; c < CHANS; c++) begin
        if (cfg_index == wtcs_pkg::CFG_MAP_FIRST + wtcs_pkg::CFG_IDX_W'(c)) begin
          map_r[c] <= cfg_data;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Timer table and window evaluation
  // ---------------------------------------------------------------------
  wtcs_pkg::bank_cmd_t  bank_cmd;
  logic [TIMERS-1:0]    valid_eff;
  logic [TIMERS-1:0]    active_eff;

  always_comb begin
    bank_cmd.tick        = in_vld_r && (kind_r == wtcs_pkg::KIND_TICK);
    bank_cmd.prog        = in_vld_r && (kind_r == wtcs_pkg::KIND_PROGRAM);
    bank_cmd.timer_index = timer_index_r;
    bank_cmd.now         = now_r;
    bank_cmd.weekday     = weekday_r;
    bank_cmd.start_sec   = start_sec_r;
    bank_cmd.stop_sec    = stop_sec_r;
    bank_cmd.days        = days_r;
  end

  wtcs_timer_bank #(
    .TIMERS (TIMERS)
  ) u_bank (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (bank_cmd),
    .valid_eff  (valid_eff),
    .active_eff (active_eff)
  );

  // ---------------------------------------------------------------------
  // Buttons and channel selection
  // ---------------------------------------------------------------------
  logic [CHANS-1:0] buttons_r;
  logic [CHANS-1:0] prev_out_r;
  logic [CHANS-1:0] buttons_upd;
  logic [CHANS-1:0] levels;

  // apply this item's button change before the channel mux
  always_comb begin
    buttons_upd = buttons_r;
    unique case (kind_r)
      wtcs_pkg::KIND_SET_ONE: begin
        for (int c = 0; c < CHANS; c++) begin
          if (chan_index_r == wtcs_pkg::CIDX_W'(c)) begin
            buttons_upd[c] = button_value_r;
          end
        end
      end
      wtcs_pkg::KIND_SET_ALL: begin
        buttons_upd = {CHANS{button_value_r}};
      end
      wtcs_pkg::KIND_TICK,
      wtcs_pkg::KIND_PROGRAM: begin
        buttons_upd = buttons_r;
      end
      default: begin
        buttons_upd = buttons_r;
      end
    endcase
  end

  wtcs_chan_mux #(
    .TIMERS (TIMERS),
    .CHANS  (CHANS)
  ) u_mux (
    .auto_mode (auto_mode_r),
    .map       (map_r),
    .buttons   (buttons_upd),
    .valid     (valid_eff),
    .active    (active_eff),
    .levels    (levels)
  );

  // buttons follow the outputs after every item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buttons_r  <= '0;
      prev_out_r <= '0;
    end else if (in_vld_r) begin
      buttons_r  <= levels;
      prev_out_r <= levels;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic                              out_valid_r;
  logic [wtcs_pkg::OUT_CH_W-1:0]     outs_nxt;
  logic [wtcs_pkg::OUT_CH_W-1:0]     changed_nxt;
  logic [wtcs_pkg::OUT_TMR_W-1:0]    timers_nxt;
  logic [wtcs_pkg::OUT_CH_W-1:0]     outs_r;
  logic [wtcs_pkg::OUT_CH_W-1:0]     changed_r;
  logic [wtcs_pkg::OUT_TMR_W-1:0]    timers_r;

  // pad missing channels and timers with zeros
  always_comb begin
    outs_nxt                = '0;
    changed_nxt             = '0;
    timers_nxt              = '0;
    outs_nxt[CHANS-1:0]     = levels;
    changed_nxt[CHANS-1:0]  = levels ^ prev_out_r;
    timers_nxt[TIMERS-1:0]  = valid_eff & active_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      outs_r    <= outs_nxt;
      changed_r <= changed_nxt;
      timers_r  <= timers_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_channel_outputs  = outs_r;
  assign out_changed_channels = changed_r;
  assign out_button_states    = outs_r;
  assign out_timers_on        = timers_r;

`ifndef NO_ASSERTIONS
  // every item in the input register yields exactly one strobe from the result register
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r |=> out_valid_r)
    else $error("result strobe missing after accepted item");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |=> !out_valid_r)
    else $error("result strobe without an item");

  // the button register must track what was reported
  a_buttons_synced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (buttons_r == outs_r[CHANS-1:0]) && (prev_out_r == buttons_r))
    else $error("buttons out of sync with reported outputs");

  // a timer is only reported on while its window is valid
  a_on_implies_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !bank_cmd.tick) |-> ((active_eff & ~valid_eff) == '0))
    else $error("timer active without valid bounds");
`endif

endmodule
